// File: design/ohist_pkg.sv
`default_nettype none
package ohist_pkg;

   // Default sizing of the block.
   localparam int TASK_SLOTS_DEF    = 16384;
   localparam int GROUP_ENTRIES_DEF = 64;
   localparam int BUCKETS_DEF       = 27;

   // Reset value of the noise threshold in nanoseconds.
   localparam logic [31:0] MIN_DELAY_RESET = 32'd1000000;

   // Field widths of the request and response ports.
   localparam int TIME_W   = 64;
   localparam int TASK_W   = 14;
   localparam int GROUP_W  = 64;
   localparam int RENTRY_W = 6;
   localparam int BUCKET_W = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 64;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_COUNTED      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_DEPARTURE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BELOW        = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_READ         = 3'd4;

   // One departure record: valid mark over the timestamp.
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] stamp;
   } departure_type;

endpackage
`default_nettype wire

// File: design/offcpu_latency_histogram.sv
`default_nettype none
// Off-CPU latency histogram per control group. A switch request stores its
// timestamp as the outgoing task's departure time, then charges the incoming
// task's off-CPU delay, if at or above csr_write_data's threshold, to a log2
// bucket of the group's histogram; a read request returns one bucket of one
// group entry. After reset the block sweeps its departure and histogram
// memories, max(TASK_SLOTS, GROUP_ENTRIES * 2^ceil(log2(BUCKETS))) addresses
// (16384 by default), and accepts no request meanwhile. A read request passes
// through S_RD to S_RESP. A switch request passes through S_DEP and S_CHK,
// and, when its delay reaches the threshold, through S_SRCH, S_HRD and S_HWR;
// in S_SRCH the group table is searched one entry per cycle up to the matching
// or newly taken entry. With the group table full and no match the response
// is STATUS_FULL. A response waits in an output register, so the next request
// is taken while it is still pending.
module offcpu_latency_histogram #(
   parameter int TASK_SLOTS    = ohist_pkg::TASK_SLOTS_DEF,
   parameter int GROUP_ENTRIES = ohist_pkg::GROUP_ENTRIES_DEF,
   parameter int BUCKETS       = ohist_pkg::BUCKETS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [31:0]                       csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic [ohist_pkg::TIME_W-1:0]      req_now_ns,
   input  wire logic [ohist_pkg::TASK_W-1:0]      req_outgoing_task,
   input  wire logic [ohist_pkg::TASK_W-1:0]      req_incoming_task,
   input  wire logic [ohist_pkg::GROUP_W-1:0]     req_group_id,
   input  wire logic [ohist_pkg::RENTRY_W-1:0]    req_read_entry,
   input  wire logic [ohist_pkg::BUCKET_W-1:0]    req_read_bucket,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ohist_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ohist_pkg::BUCKET_W-1:0]         rsp_bucket,
   output logic                                   rsp_entry_used,
   output logic [ohist_pkg::GROUP_W-1:0]          rsp_entry_group,
   output logic [ohist_pkg::COUNT_W-1:0]          rsp_bucket_count
);

   localparam int TW  = $clog2(TASK_SLOTS);
   localparam int EW  = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
   localparam int CW  = $clog2(GROUP_ENTRIES + 1);
   localparam int BW  = $clog2(BUCKETS);
   localparam int HW  = EW + BW;
   localparam int HD  = GROUP_ENTRIES * (2 ** BW);
   localparam int CLR_DEPTH = (TASK_SLOTS > HD) ? TASK_SLOTS : HD;
   localparam int CLW = $clog2(CLR_DEPTH + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEP   = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_HRD   = 4'd5;
   localparam logic [3:0] S_HWR   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   // Memories.
   ohist_pkg::departure_type           dep_mem [TASK_SLOTS];
   logic [ohist_pkg::GROUP_W-1:0]      key_mem [GROUP_ENTRIES];
   logic [ohist_pkg::COUNT_W-1:0]      hist_mem [HD];

   ohist_pkg::departure_type           dep_rd_ff;
   logic [ohist_pkg::GROUP_W-1:0]      key_rd_ff;
   logic [ohist_pkg::COUNT_W-1:0]      hist_rd_ff;

   logic                               dep_re, dep_we;
   logic [TW-1:0]                      dep_raddr, dep_waddr;
   ohist_pkg::departure_type           dep_wdata;
   logic                               key_re, key_we;
   logic [EW-1:0]                      key_raddr, key_waddr;
   logic                               hist_re, hist_we;
   logic [HW-1:0]                      hist_raddr, hist_waddr;
   logic [ohist_pkg::COUNT_W-1:0]      hist_wdata;

   // Control registers.
   logic [3:0]                         state_ff, state_in;
   logic [CLW-1:0]                     clr_ff, clr_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      idx_ff, idx_in;
   logic [31:0]                        min_delay_ff;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   logic [ohist_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [TW-1:0]                      out_task_ff, out_task_in;
   logic [TW-1:0]                      in_task_ff, in_task_in;
   logic                               out_ok_ff, out_ok_in;
   logic                               in_ok_ff, in_ok_in;
   logic [ohist_pkg::GROUP_W-1:0]      group_ff, group_in;
   logic [ohist_pkg::RENTRY_W-1:0]     rentry_ff, rentry_in;
   logic [ohist_pkg::BUCKET_W-1:0]     rbucket_ff, rbucket_in;
   logic [ohist_pkg::TIME_W-1:0]       delay_ff, delay_in;
   logic                               found_ff, found_in;
   logic                               same_ff, same_in;
   logic [BW-1:0]                      bkt_ff, bkt_in;
   logic [EW-1:0]                      entry_ff, entry_in;

   // Result held until the output register is free.
   logic [ohist_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [ohist_pkg::BUCKET_W-1:0]     res_bucket_ff, res_bucket_in;
   logic                               res_used_ff, res_used_in;
   logic [ohist_pkg::GROUP_W-1:0]      res_group_ff, res_group_in;
   logic [ohist_pkg::COUNT_W-1:0]      res_count_ff, res_count_in;

   logic [ohist_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ohist_pkg::BUCKET_W-1:0]     rsp_bucket_ff, rsp_bucket_in;
   logic                               rsp_used_ff, rsp_used_in;
   logic [ohist_pkg::GROUP_W-1:0]      rsp_group_ff, rsp_group_in;
   logic [ohist_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                               accept;
   logic                               load_rsp;
   logic                               rd_entry_ok, rd_bucket_ok, rd_used;
   logic [BW-1:0]                      log2_bkt;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_rsp  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // Read-side range checks of a read request.
   assign rd_entry_ok  = (32'(rentry_ff) < GROUP_ENTRIES);
   assign rd_bucket_ok = (32'(rbucket_ff) < BUCKETS);
   assign rd_used      = rd_entry_ok && (32'(rentry_ff) < 32'(count_ff));

   // Floor of log2 of the delay, capped at the last bucket.
   always_comb begin
      log2_bkt = '0;
      for (int i = 1; i < BUCKETS - 1; i++) begin
         if (delay_ff[i]) begin
            log2_bkt = BW'(i);
         end
      end
      if ((delay_ff >> (BUCKETS - 1)) != '0) begin
         log2_bkt = BW'(BUCKETS - 1);
      end
   end

   // Sequencer and memory control.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      out_task_in   = out_task_ff;
      in_task_in    = in_task_ff;
      out_ok_in     = out_ok_ff;
      in_ok_in      = in_ok_ff;
      group_in      = group_ff;
      rentry_in     = rentry_ff;
      rbucket_in    = rbucket_ff;
      delay_in      = delay_ff;
      found_in      = found_ff;
      same_in       = same_ff;
      bkt_in        = bkt_ff;
      entry_in      = entry_ff;
      res_status_in = res_status_ff;
      res_bucket_in = res_bucket_ff;
      res_used_in   = res_used_ff;
      res_group_in  = res_group_ff;
      res_count_in  = res_count_ff;
      dep_re        = 1'b0;
      dep_raddr     = in_task_ff;
      dep_we        = 1'b0;
      dep_waddr     = out_task_ff;
      dep_wdata     = '{valid: 1'b1, stamp: now_ff};
      key_re        = 1'b0;
      key_raddr     = '0;
      key_we        = 1'b0;
      key_waddr     = count_ff[EW-1:0];
      hist_re       = 1'b0;
      hist_raddr    = {entry_ff, bkt_ff};
      hist_we       = 1'b0;
      hist_waddr    = {entry_ff, bkt_ff};
      hist_wdata    = hist_rd_ff + 64'd1;

      case (state_ff)
         S_CLEAR: begin
            dep_waddr  = clr_ff[TW-1:0];
            dep_wdata  = '{valid: 1'b0, stamp: '0};
            dep_we     = (32'(clr_ff) < TASK_SLOTS);
            hist_waddr = clr_ff[HW-1:0];
            hist_wdata = '0;
            hist_we    = (32'(clr_ff) < HD);
            clr_in     = clr_ff + CLW'(1);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               now_in      = req_now_ns;
               out_task_in = TW'(req_outgoing_task);
               in_task_in  = TW'(req_incoming_task);
               out_ok_in   = (32'(req_outgoing_task) < TASK_SLOTS);
               in_ok_in    = (32'(req_incoming_task) < TASK_SLOTS);
               group_in    = req_group_id;
               rentry_in   = req_read_entry;
               rbucket_in  = req_read_bucket;
               if (req_op) begin
                  key_re     = 1'b1;
                  key_raddr  = EW'(req_read_entry);
                  hist_re    = 1'b1;
                  hist_raddr = {EW'(req_read_entry), BW'(req_read_bucket)};
                  state_in   = S_RD;
               end else begin
                  dep_re    = 1'b1;
                  dep_raddr = TW'(req_incoming_task);
                  state_in  = S_DEP;
               end
            end
         end
         S_DEP: begin
            // Store the outgoing departure; a task switching to itself is cleared at once.
            same_in   = in_ok_ff && out_ok_ff && (in_task_ff == out_task_ff);
            dep_we    = out_ok_ff;
            dep_wdata = '{valid: !same_in, stamp: now_ff};
            found_in  = in_ok_ff && (same_in || dep_rd_ff.valid);
            delay_in  = same_in ? '0 : (now_ff - dep_rd_ff.stamp);
            state_in  = S_CHK;
         end
         S_CHK: begin
            // Clear the incoming task's mark, then classify the delay.
            dep_we        = found_ff && !same_ff;
            dep_waddr     = in_task_ff;
            dep_wdata     = '{valid: 1'b0, stamp: dep_rd_ff.stamp};
            res_used_in   = 1'b0;
            res_group_in  = '0;
            res_bucket_in = '0;
            res_count_in  = '0;
            if (!found_ff) begin
               res_status_in = ohist_pkg::STATUS_NO_DEPARTURE;
               state_in      = S_RESP;
            end else if (delay_ff < {32'd0, min_delay_ff}) begin
               res_status_in = ohist_pkg::STATUS_BELOW;
               state_in      = S_RESP;
            end else begin
               bkt_in    = log2_bkt;
               idx_in    = '0;
               key_re    = 1'b1;
               key_raddr = '0;
               state_in  = S_SRCH;
            end
         end
         S_SRCH: begin
            // Walk the used entries one per cycle; allocate the next one on a miss if one is free.
            if (idx_ff == count_ff) begin
               if (32'(count_ff) < GROUP_ENTRIES) begin
                  key_we   = 1'b1;
                  entry_in = count_ff[EW-1:0];
                  count_in = count_ff + CW'(1);
                  state_in = S_HRD;
               end else begin
                  res_status_in = ohist_pkg::STATUS_FULL;
                  res_bucket_in = ohist_pkg::BUCKET_W'(bkt_ff);
                  state_in      = S_RESP;
               end
            end else if (key_rd_ff == group_ff) begin
               entry_in = idx_ff[EW-1:0];
               state_in = S_HRD;
            end else begin
               idx_in    = idx_ff + CW'(1);
               key_re    = 1'b1;
               key_raddr = idx_in[EW-1:0];
            end
         end
         S_HRD: begin
            hist_re  = 1'b1;
            state_in = S_HWR;
         end
         S_HWR: begin
            hist_we       = 1'b1;
            res_status_in = ohist_pkg::STATUS_COUNTED;
            res_bucket_in = ohist_pkg::BUCKET_W'(bkt_ff);
            res_count_in  = hist_wdata;
            state_in      = S_RESP;
         end
         S_RD: begin
            res_status_in = ohist_pkg::STATUS_READ;
            res_bucket_in = rbucket_ff;
            res_used_in   = rd_used;
            res_group_in  = rd_used ? key_rd_ff : '0;
            res_count_in  = (rd_entry_ok && rd_bucket_ok) ? hist_rd_ff : '0;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = (rsp_valid_ff && !rsp_ready) || load_rsp;
      rsp_status_in = load_rsp ? res_status_ff : rsp_status_ff;
      rsp_bucket_in = load_rsp ? res_bucket_ff : rsp_bucket_ff;
      rsp_used_in   = load_rsp ? res_used_ff : rsp_used_ff;
      rsp_group_in  = load_rsp ? res_group_ff : rsp_group_ff;
      rsp_count_in  = load_rsp ? res_count_ff : rsp_count_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         min_delay_ff <= ohist_pkg::MIN_DELAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            min_delay_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      out_task_ff   <= out_task_in;
      in_task_ff    <= in_task_in;
      out_ok_ff     <= out_ok_in;
      in_ok_ff      <= in_ok_in;
      group_ff      <= group_in;
      rentry_ff     <= rentry_in;
      rbucket_ff    <= rbucket_in;
      delay_ff      <= delay_in;
      found_ff      <= found_in;
      same_ff       <= same_in;
      bkt_ff        <= bkt_in;
      entry_ff      <= entry_in;
      res_status_ff <= res_status_in;
      res_bucket_ff <= res_bucket_in;
      res_used_ff   <= res_used_in;
      res_group_ff  <= res_group_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Departure memory: valid mark and timestamp per task.
   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_waddr] <= dep_wdata;
      end
      if (dep_re) begin
         dep_rd_ff <= dep_mem[dep_raddr];
      end
   end

   // Group key memory.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= group_ff;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_raddr];
      end
   end

   // Histogram memory, one row of buckets per group entry.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket       = rsp_bucket_ff;
   assign rsp_entry_used   = rsp_used_ff;
   assign rsp_entry_group  = rsp_group_ff;
   assign rsp_bucket_count = rsp_count_ff;

endmodule
`default_nettype wire
